// ===== rtl/spa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Shared widths, operation codes, status codes and controller states.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int COUNT_W   = SLOT_W + 1;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_ALLOC = 2'd0;
  localparam mode_t MODE_FREE  = 2'd1;
  localparam mode_t MODE_CHECK = 2'd2;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_RANGE     = 2'd1;
  localparam status_t STATUS_ALREADY   = 2'd2;

  localparam count_t COUNT_LIMIT = count_t'(MAX_SLOTS);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// ===== rtl/spa_if.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator channels
// Valid/ready channels for requests, responses and the configuration write.
// ----------------------------------------------------------------------------
interface spa_req_if;
  import spa_pkg::*;
  logic  valid;
  logic  ready;
  mode_t mode;
  slot_t slot_index;
  modport source (output valid, output mode, output slot_index, input ready);
  modport sink   (input valid, input mode, input slot_index, output ready);
endinterface

interface spa_rsp_if;
  import spa_pkg::*;
  logic    valid;
  logic    ready;
  slot_t   slot_out;
  status_t status;
  modport source (output valid, output slot_out, output status, input ready);
  modport sink   (input valid, input slot_out, input status, output ready);
endinterface

interface spa_cfg_if;
  import spa_pkg::*;
  logic   valid;
  logic   ready;
  count_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/slot_pool_allocator.sv =====
// A request is accepted in the idle state, its entry is read from the slot
// memory on that edge, and the response is registered when the execute state
// commits, which waits while the response is held. A new request is taken
// only in the idle state, once the read and update of the last one are done.
// Reset: synchronous, active low; the free list is empty, the bump counter
// is zero, all free marks read as clear and slot_count returns to 256.
// ----------------------------------------------------------------------------
// Slot pool allocator
// Hands out, takes back and checks fixed-size slots using a linked free list
// kept in a slot memory, backed by a bump counter for untouched slots.
// ----------------------------------------------------------------------------
module slot_pool_allocator (
  input  logic      clk,
  input  logic      rst_n,
  spa_cfg_if.sink   cfg_wr,
  spa_req_if.sink   in_req,
  spa_rsp_if.source out_rsp
);
  import spa_pkg::*;

  // Each memory word holds the free mark in its top bit and the free-list
  // link below it. The link of the last slot on the list points to itself.
  logic [SLOT_W:0]      slot_mem [MAX_SLOTS];
  logic [SLOT_W:0]      rd_data_r;
  logic                 mem_wr_en;
  slot_t                mem_wr_addr;
  logic [SLOT_W:0]      mem_wr_data;
  logic                 mem_rd_en;
  slot_t                mem_rd_addr;

  // A memory word counts only once it has been written since reset; an
  // unwritten word reads as a clear free mark.
  logic [MAX_SLOTS-1:0] written_r;

  state_t  state_r, state_nxt;
  count_t  slot_count_r;
  slot_t   free_head_r, free_head_nxt;
  logic    list_empty_r, list_empty_nxt;
  count_t  bump_r, bump_nxt;

  // Captured request and the memory address read for it.
  mode_t   op_mode_r;
  slot_t   op_idx_r;
  slot_t   op_addr_r;

  // Response register.
  logic    out_valid_r;
  slot_t   out_slot_r, out_slot_nxt;
  status_t out_status_r, out_status_nxt;

  logic    accept;
  logic    commit;
  count_t  live_count;
  logic    entry_marked;
  slot_t   entry_link;
  count_t  idx_ext;
  logic    idx_in_range;

  // Configuration always taken; user, not block, writes it only when idle.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= COUNT_LIMIT;
    end else if (cfg_wr.valid) begin
      slot_count_r <= cfg_wr.data;
    end
  end

  // The usable count is slot_count clipped to the memory depth.
  assign live_count = (slot_count_r > COUNT_LIMIT) ? COUNT_LIMIT : slot_count_r;

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;

  // An allocate reads the word at the free-list head; free and check read
  // the word of the addressed slot.
  assign mem_rd_en   = accept;
  assign mem_rd_addr = (in_req.mode == MODE_ALLOC) ? free_head_r : in_req.slot_index;

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      slot_mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data_r <= slot_mem[mem_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode_r <= in_req.mode;
      op_idx_r  <= in_req.slot_index;
      op_addr_r <= mem_rd_addr;
    end
  end

  assign entry_marked = written_r[op_addr_r] && rd_data_r[SLOT_W];
  assign entry_link   = rd_data_r[SLOT_W-1:0];
  assign idx_ext      = {1'b0, op_idx_r};
  assign idx_in_range = (idx_ext < live_count);

  // The update step runs once the response register can take a result, so a
  // stalled consumer holds the block in the execute state.
  assign commit = (state_r == ST_EXEC) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    list_empty_nxt = list_empty_r;
    bump_nxt       = bump_r;
    out_slot_nxt   = op_idx_r;
    out_status_nxt = STATUS_OK;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = op_addr_r;
    mem_wr_data    = rd_data_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_nxt = ST_IDLE;
          case (op_mode_r)
            MODE_ALLOC: begin
              if (!list_empty_r) begin
                // Pop the head: clear its mark, advance or empty the list.
                out_slot_nxt = free_head_r;
                mem_wr_en    = 1'b1;
                mem_wr_addr  = free_head_r;
                mem_wr_data  = {1'b0, entry_link};
                if (entry_link == free_head_r) begin
                  list_empty_nxt = 1'b1;
                end else begin
                  free_head_nxt = entry_link;
                end
              end else if (bump_r < live_count) begin
                out_slot_nxt = bump_r[SLOT_W-1:0];
                bump_nxt     = bump_r + count_t'(1);
              end else begin
                out_slot_nxt   = '0;
                out_status_nxt = STATUS_RANGE;
              end
            end
            MODE_FREE: begin
              if (!idx_in_range) begin
                out_status_nxt = STATUS_RANGE;
              end else if (entry_marked || (idx_ext >= bump_r)) begin
                // Already on the list, or never handed out.
                out_status_nxt = STATUS_ALREADY;
              end else if ((idx_ext + count_t'(1)) == bump_r) begin
                // Topmost bumped slot goes back to the bump counter.
                bump_nxt = bump_r - count_t'(1);
              end else begin
                mem_wr_en      = 1'b1;
                mem_wr_addr    = op_idx_r;
                mem_wr_data    = {1'b1, (list_empty_r ? op_idx_r : free_head_r)};
                free_head_nxt  = op_idx_r;
                list_empty_nxt = 1'b0;
              end
            end
            MODE_CHECK: begin
              if (!idx_in_range) begin
                out_status_nxt = STATUS_RANGE;
              end else if (entry_marked) begin
                out_status_nxt = STATUS_ALREADY;
              end
            end
            default: begin
              out_status_nxt = STATUS_RANGE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      free_head_r  <= '0;
      list_empty_r <= 1'b1;
      bump_r       <= '0;
      written_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      list_empty_r <= list_empty_nxt;
      bump_r       <= bump_nxt;
      if (mem_wr_en) begin
        written_r[mem_wr_addr] <= 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_slot_r   <= out_slot_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.slot_out = out_slot_r;
  assign out_rsp.status   = out_status_r;

endmodule
